// File: rtl/core/sacl_pkg.sv
package sacl_pkg;

	localparam int LINES_DEF = 64;
	localparam int ADDR_W    = 32;
	localparam int STAMP_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = 2'd2;

	localparam logic [3:0] OFFSET_RST = 4'd4;
	localparam logic [2:0] WAYS_RST   = 3'd2;

	localparam logic MODE_LRU  = 1'b0;
	localparam logic MODE_FIFO = 1'b1;

	typedef struct packed {
		logic [3:0] offset_bits;
		logic [2:0] ways_log2;
		logic       replace_mode;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [ADDR_W-1:0]  tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_SCAN,
		ST_WR
	} state_t;

endpackage

// File: rtl/core/sacl_lines.sv
module sacl_lines import sacl_pkg::*; #(
	parameter int LINES = LINES_DEF,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  line_t            wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output line_t            rdata
);

	line_t mem_q [LINES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/sacl_ctrl.sv
module sacl_ctrl import sacl_pkg::*; #(
	parameter int LINES = LINES_DEF,
	parameter int IDX_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              start,
	input  logic [ADDR_W-1:0] address,
	output logic              busy,
	output logic              done,
	output logic              hit,
	output logic [5:0]        line_index,
	output logic              evicted_valid,
	output logic [31:0]       hits_total,
	output logic [31:0]       misses_total
);

	localparam int L2   = $clog2(LINES + 1) - 1;
	localparam int WC_W = IDX_W + 1;
	localparam logic [3:0] L2_V = 4'(L2);

	state_t state_q, state_d;

	logic [IDX_W-1:0] clr_cnt_q;
	logic [ADDR_W-1:0] tag_q;
	logic [IDX_W-1:0] base_q;
	logic [WC_W-1:0]  ways_q;
	logic [WC_W-1:0]  rd_cnt_q;
	logic [WC_W-1:0]  cmp_cnt_q;
	logic             cmp_vld_q;
	logic             hit_q;
	logic [IDX_W-1:0] idx_q;
	logic [STAMP_W-1:0] vstamp_q;
	logic             vvalid_q;
	logic             found_inv_q;
	logic [31:0]      access_q, fill_q, hit_cnt_q, miss_cnt_q;

	// decode of the incoming address
	logic [3:0]        wl, set_bits;
	logic [ADDR_W-1:0] shifted, set_val, tag_val;

	always_comb begin
		wl       = ({1'b0, cfg.ways_log2} > L2_V) ? L2_V : {1'b0, cfg.ways_log2};
		set_bits = L2_V - wl;
		shifted  = address >> cfg.offset_bits;
		set_val  = shifted & ((ADDR_W'(1) << set_bits) - ADDR_W'(1));
		tag_val  = shifted >> set_bits;
	end

	// memory
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	line_t            mem_wdata, rdata;

	sacl_lines #(.LINES(LINES), .IDX_W(IDX_W)) u_lines (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	logic [IDX_W-1:0] cmp_line;
	logic             tag_eq, last_way, scan_end;
	logic [31:0]      now;

	assign cmp_line = base_q + cmp_cnt_q[IDX_W-1:0];
	assign tag_eq   = rdata.valid && (rdata.tag == tag_q);
	assign last_way = (cmp_cnt_q == ways_q - WC_W'(1));
	assign scan_end = cmp_vld_q && (tag_eq || last_way);
	assign now      = access_q + 32'd1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:  if (clr_cnt_q == IDX_W'(LINES - 1)) state_d = ST_IDLE;
			ST_IDLE: if (start) state_d = ST_SCAN;
			ST_SCAN: if (scan_end) state_d = ST_WR;
			ST_WR:   state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy      = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '{valid: 1'b1, tag: tag_q, stamp: vstamp_q};
		mem_re    = 1'b0;
		mem_raddr = base_q + rd_cnt_q[IDX_W-1:0];
		unique case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '{valid: 1'b0, tag: '0, stamp: '0};
			end
			ST_IDLE: busy = 1'b0;
			ST_SCAN: mem_re = (rd_cnt_q < ways_q);
			ST_WR: begin
				mem_we = 1'b1;
				if (cfg.replace_mode == MODE_LRU) begin
					mem_wdata.stamp = now;
				end else if (!hit_q) begin
					mem_wdata.stamp = fill_q;
				end
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_cnt_q  <= '0;
			cmp_vld_q  <= 1'b0;
			done       <= 1'b0;
			access_q   <= '0;
			fill_q     <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			done      <= (state_q == ST_WR);
			cmp_vld_q <= mem_re;
			if (state_q == ST_CLR) begin
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			end
			if (state_q == ST_WR) begin
				access_q <= now;
				if (hit_q) begin
					if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + 32'd1;
				end else begin
					if (miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + 32'd1;
					if (cfg.replace_mode == MODE_FIFO) fill_q <= fill_q + 32'd1;
				end
			end
		end
	end

	// scan datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			tag_q     <= tag_val;
			base_q    <= IDX_W'(set_val << wl);
			ways_q    <= WC_W'(1) << wl;
			rd_cnt_q  <= '0;
			cmp_cnt_q <= '0;
			hit_q     <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			if (mem_re) rd_cnt_q <= rd_cnt_q + WC_W'(1);
			if (cmp_vld_q) begin
				cmp_cnt_q <= cmp_cnt_q + WC_W'(1);
				if (tag_eq) begin
					hit_q    <= 1'b1;
					idx_q    <= cmp_line;
					vstamp_q <= rdata.stamp;
				end else if (cmp_cnt_q == '0) begin
					// first way seeds the victim
					idx_q       <= cmp_line;
					vstamp_q    <= rdata.stamp;
					vvalid_q    <= rdata.valid;
					found_inv_q <= !rdata.valid;
				end else if (!found_inv_q) begin
					if (!rdata.valid) begin
						idx_q       <= cmp_line;
						vvalid_q    <= 1'b0;
						found_inv_q <= 1'b1;
					end else if (rdata.stamp < vstamp_q) begin
						idx_q    <= cmp_line;
						vstamp_q <= rdata.stamp;
					end
				end
			end
		end
		if (state_q == ST_WR) begin
			hit           <= hit_q;
			line_index    <= 6'(idx_q);
			evicted_valid <= !hit_q && vvalid_q;
			hits_total    <= (hit_q && hit_cnt_q != '1) ? hit_cnt_q + 32'd1 : hit_cnt_q;
			misses_total  <= (!hit_q && miss_cnt_q != '1) ? miss_cnt_q + 32'd1 : miss_cnt_q;
		end
	end

endmodule

// File: rtl/core/set_assoc_cache_lookup.sv
// Set associative cache lookup, LRU or FIFO replacement.
// Command channel: drive address with start high; the word is taken at a
// rising edge where start is high and busy is low. busy stays high until
// the result has been produced.
// Result: done is high for exactly one cycle with hit, line_index,
// evicted_valid, hits_total and misses_total. The receiver cannot stall;
// the outputs then hold that result until the next lookup writes its own.
// Lookup: W is the ways of the set (1 << ways_log2, clamped to the used
// lines). The scan reads the W ways in turn; a hit stops it early.
// A new word may be accepted in the done cycle. The scan reads one line
// store line per cycle through its single registered read port, and a
// write-back state after the scan updates the line and the result.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; always
// ready. Index 0 offset_bits, 1 ways_log2, 2 replace_mode; others ignored.
// Reset: valid bits are cleared by a pass over every line of the line
// store, busy high meanwhile; counters and stamps clocks restart at zero.
module set_assoc_cache_lookup import sacl_pkg::*; #(
	parameter int LINES = LINES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ADDR_W-1:0]    address,
	output logic                 busy,
	output logic                 done,
	output logic                 hit,
	output logic [5:0]           line_index,
	output logic                 evicted_valid,
	output logic [31:0]          hits_total,
	output logic [31:0]          misses_total,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	// line index width; at least one bit for a single-line cache
	localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{offset_bits: OFFSET_RST, ways_log2: WAYS_RST, replace_mode: MODE_LRU};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OFFSET_BITS:  cfg_q.offset_bits  <= cfg_data;
				CFG_WAYS_LOG2:    cfg_q.ways_log2    <= cfg_data[2:0];
				CFG_REPLACE_MODE: cfg_q.replace_mode <= cfg_data[0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	sacl_ctrl #(.LINES(LINES), .IDX_W(IDX_W)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.start         (start),
		.address       (address),
		.busy          (busy),
		.done          (done),
		.hit           (hit),
		.line_index    (line_index),
		.evicted_valid (evicted_valid),
		.hits_total    (hits_total),
		.misses_total  (misses_total)
	);

endmodule

// File: tb/testbench.sv
module testbench import sacl_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NLINES = LINES_DEF;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [ADDR_W-1:0] address = '0;
	logic busy, done, hit, evicted_valid, cfg_ready;
	logic [5:0] line_index;
	logic [31:0] hits_total, misses_total;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	always #1 clk = ~clk;

	set_assoc_cache_lookup dut (.*);

	// one lookup result, as the block reports it
	typedef struct packed {
		logic        hit;
		logic [5:0]  line;
		logic        evicted;
		logic [31:0] hits;
		logic [31:0] misses;
	} lookup_t;

	// predictor state: private copy of the cache contents and settings
	logic [31:0] mdl_tag [NLINES];
	logic        mdl_valid [NLINES];
	logic [31:0] mdl_stamp [NLINES];
	logic [31:0] mdl_accesses, mdl_fills, mdl_hits, mdl_misses;
	logic [3:0]  mdl_offset;
	logic [2:0]  mdl_ways;
	logic        mdl_mode;

	lookup_t expected_lookups [$];
	int mismatches = 0;
	longint cycles = 0;

	function automatic lookup_t predict_lookup(logic [31:0] addr);
		lookup_t r;
		int l2, wl, sbits, nways, set_no, base, victim, idx;
		logic [31:0] tg, now;
		bit found, free_seen;
		l2 = $clog2(NLINES);
		wl = (mdl_ways > l2) ? l2 : mdl_ways;
		sbits = l2 - wl;
		nways = 1 << wl;
		set_no = (addr >> mdl_offset) & ((1 << sbits) - 1);
		tg = addr >> (mdl_offset + sbits);
		base = set_no * nways;
		now = mdl_accesses + 1;
		victim = base;
		idx = base;
		found = 0;
		free_seen = 0;
		for (int j = base; j < base + nways; j++) begin
			if (mdl_valid[j]) begin
				if (mdl_tag[j] == tg) begin
					found = 1;
					idx = j;
					break;
				end
				if (!free_seen && mdl_stamp[j] < mdl_stamp[victim])
					victim = j;
			end else if (!free_seen) begin
				free_seen = 1;
				victim = j;
			end
		end
		if (!found && !mdl_valid[base])
			victim = base;
		r.evicted = 1'b0;
		if (found) begin
			if (mdl_mode == MODE_LRU)
				mdl_stamp[idx] = now;
			if (mdl_hits != '1)
				mdl_hits++;
		end else begin
			idx = victim;
			r.evicted = mdl_valid[idx];
			mdl_tag[idx] = tg;
			mdl_valid[idx] = 1'b1;
			if (mdl_mode == MODE_LRU) begin
				mdl_stamp[idx] = now;
			end else begin
				mdl_stamp[idx] = mdl_fills;
				mdl_fills++;
			end
			if (mdl_misses != '1)
				mdl_misses++;
		end
		mdl_accesses = now;
		r.hit = found;
		r.line = idx[5:0];
		r.hits = mdl_hits;
		r.misses = mdl_misses;
		return r;
	endfunction

	// result checker: done marks one result word, no back-pressure possible
	always @(posedge clk) begin
		lookup_t got, want;
		if (done) begin
			got = '{hit, line_index, evicted_valid, hits_total, misses_total};
			if (expected_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %p", got);
			end else begin
				want = expected_lookups.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	bit no_gaps = 0;

	// send one address word; predict its result on acceptance
	// start stays high after acceptance; a gap or wait_idle drops it
	task automatic send_address(logic [31:0] addr);
		int g;
		g = no_gaps ? 0 : pick_gap();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
		start <= 1'b1;
		address <= addr;
		do @(posedge clk); while (busy);
		expected_lookups.insert(expected_lookups.size(), predict_lookup(addr));
	endtask

	// drain outstanding results, then allow a few idle cycles
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_lookups.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_OFFSET_BITS:  mdl_offset = val[3:0];
			CFG_WAYS_LOG2:    mdl_ways = val[2:0];
			CFG_REPLACE_MODE: mdl_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [3:0] off, logic [2:0] wl, logic mode);
		wait_idle();
		write_reg(CFG_OFFSET_BITS, off);
		write_reg(CFG_WAYS_LOG2, {1'b0, wl});
		write_reg(CFG_REPLACE_MODE, {3'b0, mode});
		cfg_valid <= 1'b0;
	endtask

	// addresses drawn from a small pool of tags so sets refill and evict
	function automatic logic [31:0] local_address(int span);
		logic [31:0] a;
		a = $urandom;
		a = (a & ~(32'hFFFF_FFFF << mdl_offset)) |
			(($urandom_range(span - 1)) << mdl_offset);
		return a;
	endfunction

	task automatic test_directed_extremes();
		send_address(32'h0000_0000);
		send_address(32'h0000_0000);
		send_address(32'hFFFF_FFFF);
		send_address(32'hFFFF_FFFF);
		send_address(32'h8000_0000);
		send_address(32'h5555_5555);
		send_address(32'hAAAA_AAAA);
		send_address(32'h0000_000F);
	endtask

	// fill one set past its ways so both policies must pick a victim
	task automatic test_set_eviction(logic mode);
		configure(4'd4, 3'd2, mode);
		for (int k = 0; k < 6; k++)
			send_address(32'h0001_0000 * k);
		send_address(32'h0000_0000);
		send_address(32'h0005_0000);
		send_address(32'h0002_0000);
	endtask

	task automatic test_geometry_extremes();
		configure(4'd0, 3'd0, MODE_LRU);
		send_address(32'h0000_0003);
		send_address(32'h0000_0043);
		configure(4'd15, 3'd7, MODE_FIFO);   // ways clamped: fully associative
		send_address(32'hFFFF_8000);
		send_address(32'h0000_7FFF);
		configure(4'd12, 3'd6, MODE_LRU);
		send_address(32'h1234_5000);
	endtask

	task automatic test_random(int n);
		logic [3:0] off;
		int span;
		for (int ph = 0; ph < 8; ph++) begin
			off = (ph == 0) ? 4'd0 : (ph == 1) ? 4'd15 : 4'($urandom_range(15));
			configure(off, 3'($urandom_range(7)), 1'($urandom_range(1)));
			no_gaps = (ph == 3);
			span = 1 << $urandom_range(9, 5);
			for (int k = 0; k < n / 8; k++)
				send_address(($urandom_range(9) == 0) ? $urandom : local_address(span));
		end
		no_gaps = 0;
	endtask

	initial begin
		for (int i = 0; i < NLINES; i++) begin
			mdl_tag[i] = '0;
			mdl_valid[i] = 1'b0;
			mdl_stamp[i] = '0;
		end
		mdl_accesses = '0;
		mdl_fills = '0;
		mdl_hits = '0;
		mdl_misses = '0;
		mdl_offset = OFFSET_RST;
		mdl_ways = WAYS_RST;
		mdl_mode = MODE_LRU;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_set_eviction(MODE_LRU);
		test_set_eviction(MODE_FIFO);
		test_geometry_extremes();
		test_random(824);
		wait_idle();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && expected_lookups.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
